// ===== rtl/rtpq_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpq_pkg: shared types and constants of the tile quantizer
// Lane record handed from cell to cell, channel expansion table, sizes.
// ----------------------------------------------------------------------------
package rtpq_pkg;

  localparam int CfgRegs    = 4;   // palette registers
  localparam int CFG_IDX_W  = 8;
  localparam int REG_SEL_W  = 2;
  localparam int PAL_W      = 60;
  localparam int WORD_W     = 15;
  localparam int CHAN_W     = 8;
  localparam int SQ_W       = 16;
  localparam int DIST_W     = 18;
  localparam int IDX_W      = 4;
  localparam int NUM_ENTRY  = 16;
  localparam int TILE_BYTES = 32;
  localparam int HALF_BYTES = 16;
  localparam int POS_W      = 6;
  localparam int OFF_W      = 5;
  localparam int CNT_W      = 6;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [POS_W-1:0]  POS_LAST = '1;

  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              opaque;
  } pix_t;

  typedef struct packed {
    logic             valid;
    pix_t             pix;
    dist_t            best_dist;
    logic [IDX_W-1:0] best_idx;
  } lane_t;

  // 5-bit channel to 8 bits, rounded as (v*255+15)/31
  function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
    logic [CHAN_W-1:0] w;
    case (v)
      5'd0:  w = 8'd0;
      5'd1:  w = 8'd8;
      5'd2:  w = 8'd16;
      5'd3:  w = 8'd25;
      5'd4:  w = 8'd33;
      5'd5:  w = 8'd41;
      5'd6:  w = 8'd49;
      5'd7:  w = 8'd58;
      5'd8:  w = 8'd66;
      5'd9:  w = 8'd74;
      5'd10: w = 8'd82;
      5'd11: w = 8'd90;
      5'd12: w = 8'd99;
      5'd13: w = 8'd107;
      5'd14: w = 8'd115;
      5'd15: w = 8'd123;
      5'd16: w = 8'd132;
      5'd17: w = 8'd140;
      5'd18: w = 8'd148;
      5'd19: w = 8'd156;
      5'd20: w = 8'd165;
      5'd21: w = 8'd173;
      5'd22: w = 8'd181;
      5'd23: w = 8'd189;
      5'd24: w = 8'd197;
      5'd25: w = 8'd206;
      5'd26: w = 8'd214;
      5'd27: w = 8'd222;
      5'd28: w = 8'd230;
      5'd29: w = 8'd239;
      5'd30: w = 8'd247;
      default: w = 8'd255;
    endcase
    return w;
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {8'b0, d} * {8'b0, d};
  endfunction

endpackage

// ===== rtl/rtpq_if.sv =====
// ----------------------------------------------------------------------------
// rtpq_if: stream channels of the tile quantizer
// Pixel channel in, tile byte channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtpq_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rtpq_byte_if;
  logic       valid;
  logic       ready;
  logic [4:0] byte_offset;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, byte_offset, byte_value, last_byte, input ready);
  modport sink   (input valid, byte_offset, byte_value, last_byte, output ready);
endinterface

// ===== rtl/rtpq_match_cell.sv =====
// ----------------------------------------------------------------------------
// rtpq_match_cell: one palette entry of the nearest-color chain
// Squares channel differences, then keeps the lane's best if beaten.
// ----------------------------------------------------------------------------
module rtpq_match_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [rtpq_pkg::IDX_W-1:0]    entry_idx,
  input  logic [rtpq_pkg::WORD_W-1:0]   word,
  input  rtpq_pkg::lane_t               lane_in,
  output rtpq_pkg::lane_t               lane_out
);
  import rtpq_pkg::*;

  lane_t           a_r;
  lane_t           b_r;
  lane_t           b_nxt;
  logic [SQ_W-1:0] sq_red_r, sq_grn_r, sq_blu_r;
  logic [SQ_W-1:0] sq_red_nxt, sq_grn_nxt, sq_blu_nxt;
  dist_t           dist_sum;

  always_comb begin
    sq_red_nxt = sq_diff(lane_in.pix.red,   widen5(word[4:0]));
    sq_grn_nxt = sq_diff(lane_in.pix.green, widen5(word[9:5]));
    sq_blu_nxt = sq_diff(lane_in.pix.blue,  widen5(word[14:10]));
  end

  // strict less: on a tie the earlier (lower) entry stays
  always_comb begin
    dist_sum = {2'b0, sq_red_r} + {2'b0, sq_grn_r} + {2'b0, sq_blu_r};
    b_nxt    = a_r;
    if (dist_sum < a_r.best_dist) begin
      b_nxt.best_dist = dist_sum;
      b_nxt.best_idx  = entry_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
      b_r.valid <= 1'b0;
    end else if (adv) begin
      a_r      <= lane_in;
      sq_red_r <= sq_red_nxt;
      sq_grn_r <= sq_grn_nxt;
      sq_blu_r <= sq_blu_nxt;
      b_r      <= b_nxt;
    end
  end

  assign lane_out = b_r;

endmodule

// ===== rtl/rtpq_plane_packer.sv =====
// ----------------------------------------------------------------------------
// rtpq_plane_packer: bit-plane tile builder and byte burst
// Shifts index bits into plane bytes, rows into tile halves, then bursts.
// ----------------------------------------------------------------------------
module rtpq_plane_packer (
  input  logic            clk,
  input  logic            rst_n,
  input  rtpq_pkg::lane_t tail,
  output logic            hold,
  rtpq_byte_if.source     out_byte
);
  import rtpq_pkg::*;

  logic [POS_W-1:0]                pos_r;
  logic [IDX_W-1:0][7:0]           row_r, row_nxt;
  logic [HALF_BYTES-1:0][7:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [TILE_BYTES-1:0][7:0]      obuf_r, obuf_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [OFF_W-1:0]                off_r, off_nxt;
  logic [IDX_W-1:0]                idx;
  logic                            take;
  logic                            beat;

  assign hold = tail.valid && (pos_r == POS_LAST) && (cnt_r != '0);
  assign take = tail.valid && !hold;
  assign beat = out_byte.valid && out_byte.ready;
  assign idx  = tail.pix.opaque ? tail.best_idx : '0;

  always_comb begin
    for (int p = 0; p < IDX_W; p++) begin
      row_nxt[p] = {row_r[p][6:0], idx[p]};
    end
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    // row complete: planes 0/1 into the low half, 2/3 into the high half
    if (pos_r[2:0] == 3'd7) begin
      for (int i = 0; i < HALF_BYTES - 2; i++) begin
        lo_nxt[i] = lo_r[i+2];
        hi_nxt[i] = hi_r[i+2];
      end
      lo_nxt[HALF_BYTES-2] = row_nxt[0];
      lo_nxt[HALF_BYTES-1] = row_nxt[1];
      hi_nxt[HALF_BYTES-2] = row_nxt[2];
      hi_nxt[HALF_BYTES-1] = row_nxt[3];
    end
  end

  always_comb begin
    obuf_nxt = obuf_r;
    cnt_nxt  = cnt_r;
    off_nxt  = off_r;
    if (beat) begin
      for (int i = 0; i < TILE_BYTES - 1; i++) begin
        obuf_nxt[i] = obuf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      off_nxt = off_r + OFF_W'(1);
    end
    if (take && (pos_r == POS_LAST)) begin
      obuf_nxt = {hi_nxt, lo_nxt};
      cnt_nxt  = CNT_W'(TILE_BYTES);
      off_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      off_r <= '0;
    end else begin
      if (take) begin
        pos_r <= pos_r + POS_W'(1);
        row_r <= row_nxt;
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
      end
      obuf_r <= obuf_nxt;
      cnt_r  <= cnt_nxt;
      off_r  <= off_nxt;
    end
  end

  assign out_byte.valid       = (cnt_r != '0);
  assign out_byte.byte_value  = obuf_r[0];
  assign out_byte.byte_offset = off_r;
  assign out_byte.last_byte   = (off_r == OFF_W'(TILE_BYTES - 1));

endmodule

// ===== rtl/rgba_to_planar_tile_quantizer.sv =====
// ----------------------------------------------------------------------------
// rgba_to_planar_tile_quantizer: nearest-palette 4bpp planar tile encoder
// Output: once the 64th pixel of a tile reaches the packer, the tile's 32 bytes
//   leave from its output buffer one per cycle while the sink is ready.
// Throughput: one pixel per cycle, set by the chain of 15 two-stage cells;
//   input stalls only when a tile completes before the previous burst is out.
// Reset (sync, active low) clears the palette, pixel position and valids.
// ----------------------------------------------------------------------------
module rgba_to_planar_tile_quantizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rtpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpq_pkg::PAL_W-1:0]         cfg_wr_data,
  rtpq_pixel_if.sink                         in_pix,
  rtpq_byte_if.source                        out_byte
);
  import rtpq_pkg::*;

  // palette registers, four BGR555 words each
  logic [PAL_W-1:0] pal_r [CfgRegs];

  // lane 0 is the incoming pixel, lane n leaves the cell of entry n
  lane_t lanes [NUM_ENTRY];

  // whole chain moves together; frozen only while the packer holds
  logic hold;
  logic adv;

  assign adv          = !hold;
  assign in_pix.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CfgRegs; i++) begin
        pal_r[i] <= '0;
      end
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(CfgRegs))) begin
      // indexes beyond the register list are dropped
      pal_r[cfg_index[REG_SEL_W-1:0]] <= cfg_wr_data;
    end
  end

  // seed: worst distance so entry 1 always wins its compare
  always_comb begin
    lanes[0].valid      = in_pix.valid;
    lanes[0].pix.red    = in_pix.red;
    lanes[0].pix.green  = in_pix.green;
    lanes[0].pix.blue   = in_pix.blue;
    lanes[0].pix.opaque = in_pix.alpha[7];
    lanes[0].best_dist  = DIST_MAX;
    lanes[0].best_idx   = '0;
  end

  // entries 1..15 in ascending order, so ties keep the lower index;
  // entry 0 sits in the palette but never joins the search
  for (genvar n = 1; n < NUM_ENTRY; n++) begin : g_cell
    rtpq_match_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .entry_idx (IDX_W'(n)),
      .word      (pal_r[n >> 2][(n & 3) * WORD_W +: WORD_W]),
      .lane_in   (lanes[n-1]),
      .lane_out  (lanes[n])
    );
  end

  // transparent pixels become index 0 in the packer
  rtpq_plane_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .tail     (lanes[NUM_ENTRY-1]),
    .hold     (hold),
    .out_byte (out_byte)
  );

endmodule

// ===== rtl/rtpq_checker.sv =====
// ----------------------------------------------------------------------------
// rtpq_checker: port-level checks of the tile quantizer
// Burst ordering, last flag and output stall behavior.
// ----------------------------------------------------------------------------
module rtpq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] byte_offset,
  input logic [7:0] byte_value,
  input logic       last_byte
);

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_offset) && $stable(byte_value))
    else $error("stalled tile byte changed");

  // a burst has no gaps and counts up by one
  a_burst_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_byte |=>
      out_valid && (byte_offset == $past(byte_offset) + 5'd1))
    else $error("tile burst broken");

  // last flag marks exactly the top address
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_byte == (byte_offset == 5'd31)))
    else $error("last flag off the final byte");

  // a new burst starts at address zero
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (byte_offset == 5'd0))
    else $error("burst does not start at zero");

endmodule

bind rgba_to_planar_tile_quantizer rtpq_checker u_rtpq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_byte.valid),
  .out_ready   (out_byte.ready),
  .byte_offset (out_byte.byte_offset),
  .byte_value  (out_byte.byte_value),
  .last_byte   (out_byte.last_byte)
);

// ===== sim/tile_bytes_checker.sv =====
// ----------------------------------------------------------------------------
// tile_bytes_checker: planar tile prediction and byte compare
// Watches the palette writes and the pixel beats, rebuilds each 8x8 tile by
// nearest-palette search and compares every tile byte beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_bytes_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rtpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtpq_pkg::PAL_W-1:0]     cfg_wr_data,
  rtpq_pixel_if                          in_pix,
  rtpq_byte_if                           out_byte,
  output int                             fail_count,
  output int                             pending_bytes
);
  import rtpq_pkg::*;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [CHAN_W-1:0] value;
    logic              is_last;
  } tile_byte_t;

  logic [PAL_W-1:0]  pal_copy [CfgRegs];
  logic [CHAN_W-1:0] tile_planes [TILE_BYTES];
  logic [POS_W-1:0]  next_pos;
  tile_byte_t        due_bytes [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int widen_channel(input logic [4:0] v);
    return (int'(v) * 255 + 15) / 31;
  endfunction

  function automatic int chan_err(input logic [CHAN_W-1:0] a, input int b);
    int d;
    d = int'(a) - b;
    return d * d;
  endfunction

  // entry 0 never takes part; strict less-than keeps the lowest index on ties
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
    logic [IDX_W-1:0]  best;
    int                best_err;
    int                err;
    logic [WORD_W-1:0] word;
    best     = IDX_W'(1);
    best_err = 32'h7FFF_FFFF;
    for (int n = 1; n < NUM_ENTRY; n++) begin
      word = WORD_W'(pal_copy[n / 4] >> (WORD_W * (n % 4)));
      err  = chan_err(r, widen_channel(word[4:0]))
           + chan_err(g, widen_channel(word[9:5]))
           + chan_err(b, widen_channel(word[14:10]));
      if (err < best_err) begin
        best_err = err;
        best     = IDX_W'(n);
      end
    end
    return best;
  endfunction

  function automatic void place_index(input logic [POS_W-1:0] pos,
                                      input logic [IDX_W-1:0] idx);
    int addr;
    for (int p = 0; p < IDX_W; p++) begin
      addr = ((p >= 2) ? HALF_BYTES : 0) + int'(pos[5:3]) * 2 + (p % 2);
      tile_planes[addr][7 - int'(pos[2:0])] = idx[p];
    end
  endfunction

  always @(posedge clk) begin
    logic [IDX_W-1:0] pix_idx;
    tile_byte_t       want;
    if (!rst_n) begin
      foreach (pal_copy[i]) pal_copy[i] = '0;
      next_pos = '0;
      due_bytes.delete();
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        if (in_pix.alpha < 8'd128) begin
          pix_idx = '0;
        end else begin
          pix_idx = nearest_entry(in_pix.red, in_pix.green, in_pix.blue);
        end
        place_index(next_pos, pix_idx);
        if (next_pos == POS_LAST) begin
          for (int k = 0; k < TILE_BYTES; k++) begin
            due_bytes.push_back('{offset: OFF_W'(k), value: tile_planes[k],
                                  is_last: (k == TILE_BYTES - 1)});
          end
        end
        next_pos = next_pos + POS_W'(1);
      end
      if (out_byte.valid && out_byte.ready) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, byte_offset %0d with no tile due",
                                    out_byte.byte_offset));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte.byte_offset !== want.offset)
            report_mismatch($sformatf("byte_offset got %0d expected %0d",
                                      out_byte.byte_offset, want.offset));
          if (out_byte.byte_value !== want.value)
            report_mismatch($sformatf("byte_value at offset %0d got %02h expected %02h",
                                      want.offset, out_byte.byte_value, want.value));
          if (out_byte.last_byte !== want.is_last)
            report_mismatch($sformatf("last_byte at offset %0d got %0b expected %0b",
                                      want.offset, out_byte.last_byte, want.is_last));
        end
      end
      if (cfg_wr_en && (cfg_index < CFG_IDX_W'(CfgRegs)))
        pal_copy[cfg_index[REG_SEL_W-1:0]] = cfg_wr_data;
    end
    pending_bytes <= due_bytes.size();
  end

endmodule

// ===== sim/rgba_to_planar_tile_quantizer_test.sv =====
// ----------------------------------------------------------------------------
// rgba_to_planar_tile_quantizer_test: tile quantizer regression
// Loads several palettes, streams whole 8x8 pixel tiles, most with random gaps
// on both channels, and lets the checker predict and compare each tile byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgba_to_planar_tile_quantizer_test;
  import rtpq_pkg::*;

  localparam int TILE_PIXELS  = 64;
  localparam int DRAIN_CYCLES = 40;    // extra wait once no tile byte is pending
  localparam int STALL_LIMIT  = 2000;  // cycles without any beat
  localparam logic [PAL_W-1:0] PAL_ALL_ONES = '1;

  // hand-made palette: primaries, grays, a duplicated red and white for ties,
  // a dark red two steps from black, and an orange only in the unused entry
  localparam logic [PAL_W-1:0] PAL_SHOWCASE [CfgRegs] = '{
    {15'h001F, 15'h7FFF, 15'h0000, 15'h021F},
    {15'h0002, 15'h001F, 15'h7C00, 15'h03E0},
    {15'h7C1F, 15'h7FE0, 15'h3DEF, 15'h4210},
    {15'h7FFF, 15'h5EF7, 15'h2108, 15'h03FF}
  };

  // directed pixels as {red, green, blue, alpha}
  localparam int DIRECTED_N = 24;
  localparam logic [31:0] DIRECTED_PIX [DIRECTED_N] = '{
    32'h0000_0000,  // all zero, transparent
    32'hFFFF_FFFF,  // white, tie between two white entries
    32'hFFFF_FF7F,  // alpha just below the threshold
    32'h0000_0080,  // alpha right at the threshold
    32'hFF00_00FF,  // red, tie between two red entries
    32'h00FF_00C8,
    32'h0000_FF80,
    32'h0800_00FF,  // halfway between black and dark red
    32'h1000_00FF,
    32'hFF84_00FF,  // color held only by entry zero
    32'h8484_84FF,
    32'h8080_80FF,
    32'h7F7F_7FFF,
    32'h00FF_FFFF,
    32'hFF00_FFFF,
    32'hFFFF_00FF,
    32'h4242_42FF,
    32'hBDBD_BDFF,
    32'hFFFF_FF00,
    32'h0000_00FF,
    32'hAA55_AAFF,
    32'h55AA_5581,
    32'hFFFF_FFFE,
    32'h01FE_7FFF
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAL_W-1:0]     cfg_wr_data;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_cycles = 0;
  int fail_count;
  int pending_bytes;

  // palette as last written, used to aim random pixels near real entries
  logic [PAL_W-1:0] pal_now [CfgRegs];

  rtpq_pixel_if in_pix ();
  rtpq_byte_if  out_byte ();

  rgba_to_planar_tile_quantizer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_pix      (in_pix),
    .out_byte    (out_byte)
  );

  tile_bytes_checker i_tile_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_pix        (in_pix),
    .out_byte      (out_byte),
    .fail_count    (fail_count),
    .pending_bytes (pending_bytes)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // byte sink: ready drops at random by the current idle share
  always @(posedge clk) begin
    out_byte.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog: too long without a pixel or byte beat ends the run
  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_byte.valid && out_byte.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one register write per cycle; caller drops the write enable afterwards
  task automatic write_reg(input int idx, input logic [PAL_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_IDX_W'(idx);
    cfg_wr_data <= data;
    if (idx < CfgRegs) pal_now[idx] = data;
    @(posedge clk);
  endtask

  // optional idle cycles, then hold the beat until ready is seen
  task automatic send_pixel(input logic [31:0] rgba);
    while ($urandom_range(99) < src_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    {in_pix.red, in_pix.green, in_pix.blue, in_pix.alpha} <= rgba;
    do @(posedge clk); while (!in_pix.ready);
  endtask

  // mostly colors close to a palette entry, where ties and near misses live;
  // the rest fully random or pinned to the channel extremes or mid values
  function automatic logic [31:0] random_pixel();
    logic [WORD_W-1:0] word;
    logic [4:0]        v;
    logic [CHAN_W-1:0] ch [3];
    logic [CHAN_W-1:0] alpha;
    int                kind;
    int                n;
    int                c;
    kind = $urandom_range(9);
    n    = $urandom_range(NUM_ENTRY - 1, 1);
    word = WORD_W'(pal_now[n / 4] >> (WORD_W * (n % 4)));
    for (int i = 0; i < 3; i++) begin
      if (kind < 5) begin
        v = word[5 * i +: 5];
        c = int'({v, v[4:2]}) + int'($urandom_range(12)) - 6;
        ch[i] = (c < 0) ? 8'd0 : (c > 255) ? 8'd255 : CHAN_W'(c);
      end else if (kind < 8) begin
        ch[i] = CHAN_W'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0:       ch[i] = 8'd0;
          1:       ch[i] = 8'd255;
          2:       ch[i] = 8'd127;
          default: ch[i] = 8'd128;
        endcase
      end
    end
    case ($urandom_range(7))
      0:       alpha = 8'd127;
      1:       alpha = 8'd128;
      2, 3:    alpha = CHAN_W'($urandom_range(127));
      default: alpha = CHAN_W'($urandom_range(255, 128));
    endcase
    return {ch[0], ch[1], ch[2], alpha};
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // wait for the last tile's bytes, then let the pipeline run dry
  task automatic settle();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    // pixel and config inputs known from time zero; the sink block owns ready
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= '0;
    cfg_wr_data    <= '0;
    in_pix.valid   <= 1'b0;
    in_pix.red     <= '0;
    in_pix.green   <= '0;
    in_pix.blue    <= '0;
    in_pix.alpha   <= '0;
    foreach (pal_now[i]) pal_now[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // tile 1: hand-made palette, directed pixels then random fill;
    // sender idles a third of the time, sink more than half
    src_idle_pct = 33;
    snk_idle_pct = 57;
    for (int i = 0; i < CfgRegs; i++) write_reg(i, PAL_SHOWCASE[i]);
    cfg_wr_en <= 1'b0;
    foreach (DIRECTED_PIX[i]) send_pixel(DIRECTED_PIX[i]);
    send_random(TILE_PIXELS - DIRECTED_N);
    settle();

    // tile 2: writes beyond the register list must change nothing,
    // then every entry set to white
    write_reg(CfgRegs, PAL_W'({$urandom(), $urandom()}));
    write_reg((1 << CFG_IDX_W) - 1, PAL_W'({$urandom(), $urandom()}));
    write_reg($urandom_range((1 << CFG_IDX_W) - 2, CfgRegs + 1), PAL_W'({$urandom(), $urandom()}));
    for (int i = 0; i < CfgRegs; i++) write_reg(i, PAL_ALL_ONES);
    cfg_wr_en <= 1'b0;
    send_random(TILE_PIXELS);
    settle();

    // tile 3: random palette, idle shares swapped
    src_idle_pct = 57;
    snk_idle_pct = 33;
    for (int i = 0; i < CfgRegs; i++) write_reg(i, PAL_W'({$urandom(), $urandom()}));
    cfg_wr_en <= 1'b0;
    send_random(TILE_PIXELS);
    settle();

    // tile 4: all-zero palette, both sides at full rate
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int i = 0; i < CfgRegs; i++) write_reg(i, '0);
    cfg_wr_en <= 1'b0;
    send_random(TILE_PIXELS);
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== rgba_to_planar_tile_quantizer.f =====
rtl/rtpq_pkg.sv
rtl/rtpq_if.sv
rtl/rtpq_match_cell.sv
rtl/rtpq_plane_packer.sv
rtl/rgba_to_planar_tile_quantizer.sv
rtl/rtpq_checker.sv
sim/tile_bytes_checker.sv
sim/rgba_to_planar_tile_quantizer_test.sv
